@@ src/bdq_pkg.sv @@
// Package with the command and status codes and the item types of the deque.
`timescale 1ns / 1ps

package bdq_pkg;

	// Command codes carried in the command field.
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE     = 3'd4,
		CMD_SEARCH     = 3'd5
	} cmd_t;

	// Status codes returned with every result item.
	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_EMPTY     = 2'd1,
		STS_FULL      = 2'd2,
		STS_NOT_FOUND = 2'd3
	} status_t;

	// One command item.
	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] operand_value;
	} cmd_item_t;

	// One result item.
	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] result_value;
		logic [3:0]         position;
		logic [4:0]         occupancy;
	} rsp_item_t;

endpackage

@@ src/bdq_stream_if.sv @@
// Valid/ready channel interface that carries one item of type T.
`timescale 1ns / 1ps

interface bdq_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ src/bdq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/bounded_deque_with_search.sv @@
// Top level of the bounded deque: ring store in RAM, command sequencer and result register.
`timescale 1ns / 1ps

// Bounded double-ended queue of signed 32-bit values with search and remove.
// Commands arrive on the cmd channel and every command yields exactly one
// result item on the rsp channel, in order. Both channels are valid/ready;
// an item moves at a rising edge with valid and ready high.
// The values sit in a ring in one RAM with a registered read; the
// sequencer handles one command at a time and cmd.ready is high while it idles.
// Pushes, unused codes and failing commands go from idle straight to the
// response state; pops pass through a read state first. Search and remove walk
// the entries from the front, one RAM read per cycle, until a match or the
// last entry. A remove then closes the gap with one read and one write back
// per cycle, moving each entry behind the match one place toward the front.
// Reset clears the head index and the entry count; the RAM is not cleared,
// since an entry is read only after it was written.
// A finished result waits in an output register. While the receiver stalls,
// the next command is still accepted and worked on; its result waits until
// the output register is free.
module bounded_deque_with_search #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	bdq_stream_if.sink   cmd,
	bdq_stream_if.source rsp
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_SCAN,
		S_SHIFT,
		S_RESP
	} state_t;

	state_t           state_q;
	logic [IW-1:0]    head_q;
	logic [CW-1:0]    count_q;
	logic [2:0]       op_q;
	logic [31:0]      val_q;
	logic [IW-1:0]    k_q;
	logic [IW-1:0]    rd_idx_q;
	logic [IW-1:0]    cmp_idx_q;
	logic [IW-1:0]    wr_idx_q;
	logic [IW-1:0]    left_q;
	logic [1:0]       sts_q;
	logic [31:0]      res_q;
	logic [3:0]       pos_q;
	logic             rsp_valid_q;
	bdq_pkg::rsp_item_t rsp_q;

	logic             ram_we;
	logic [IW-1:0]    ram_waddr;
	logic [31:0]      ram_wdata;
	logic [IW-1:0]    ram_raddr;
	logic [31:0]      ram_rdata;

	logic             cmd_fire;
	logic             rsp_load;
	logic             is_full;
	logic             is_empty;
	logic             match;
	logic             last_k;
	logic [CW-1:0]    rest;
	logic [IW-1:0]    back_idx;
	logic [IW-1:0]    tail_idx;

	// Ring index arithmetic with wrap at CAPACITY.
	function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] i);
		return (i == IW'(CAPACITY - 1)) ? '0 : IW'(i + 1'b1);
	endfunction

	function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] i);
		return (i == '0) ? IW'(CAPACITY - 1) : IW'(i - 1'b1);
	endfunction

	function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
			input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IW+1)'(CAPACITY)) begin
			s = s - (IW+1)'(CAPACITY);
		end
		return s[IW-1:0];
	endfunction

	// Entry store.
	bdq_ram #(
		.WIDTH (32),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Handshake and derived conditions.
	assign cmd.ready = (state_q == S_IDLE);
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;
	assign rsp_load  = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);
	assign back_idx = ring_add(head_q, IW'(count_q));
	assign tail_idx = ring_add(head_q, IW'(count_q - CW'(1)));
	assign match    = (ram_rdata == val_q);
	assign last_k   = ((CW'(k_q) + CW'(1)) == count_q);
	assign rest     = CW'(count_q - CW'(1) - CW'(k_q));

	// RAM port control: pushes write in idle, the gap closing writes back
	// what was read in the cycle before. Reads always run ahead of the writes.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_idx_q;
		ram_wdata = ram_rdata;
		ram_raddr = rd_idx_q;
		unique case (state_q)
			S_IDLE: begin
				ram_wdata = cmd.payload.operand_value;
				ram_raddr = head_q;
				if (cmd_fire && !is_full) begin
					if (cmd.payload.command == bdq_pkg::CMD_PUSH_FRONT) begin
						ram_we    = 1'b1;
						ram_waddr = idx_dec(head_q);
					end else if (cmd.payload.command == bdq_pkg::CMD_PUSH_BACK) begin
						ram_we    = 1'b1;
						ram_waddr = back_idx;
					end
				end
				if (cmd.payload.command == bdq_pkg::CMD_POP_BACK) begin
					ram_raddr = tail_idx;
				end
			end
			S_SHIFT: begin
				ram_we = 1'b1;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Sequencer, deque pointers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			op_q        <= '0;
			val_q       <= '0;
			k_q         <= '0;
			rd_idx_q    <= '0;
			cmp_idx_q   <= '0;
			wr_idx_q    <= '0;
			left_q      <= '0;
			sts_q       <= bdq_pkg::STS_OK;
			res_q       <= '0;
			pos_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// The output register fills from the response state and empties on accept.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_fire) begin
						op_q      <= cmd.payload.command;
						val_q     <= cmd.payload.operand_value;
						sts_q     <= bdq_pkg::STS_OK;
						res_q     <= '0;
						pos_q     <= '0;
						k_q       <= '0;
						rd_idx_q  <= idx_inc(head_q);
						cmp_idx_q <= head_q;
						state_q   <= S_RESP;
						case (cmd.payload.command)
							bdq_pkg::CMD_PUSH_FRONT: begin
								if (is_full) begin
									sts_q <= bdq_pkg::STS_FULL;
								end else begin
									head_q  <= idx_dec(head_q);
									count_q <= count_q + CW'(1);
								end
							end
							bdq_pkg::CMD_PUSH_BACK: begin
								if (is_full) begin
									sts_q <= bdq_pkg::STS_FULL;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_BACK: begin
								if (is_empty) begin
									sts_q <= bdq_pkg::STS_EMPTY;
								end else begin
									state_q <= S_READ;
								end
							end
							bdq_pkg::CMD_REMOVE, bdq_pkg::CMD_SEARCH: begin
								if (is_empty) begin
									sts_q <= bdq_pkg::STS_EMPTY;
								end else begin
									state_q <= S_SCAN;
								end
							end
							default: begin
								sts_q <= bdq_pkg::STS_OK;
							end
						endcase
					end
				end
				S_READ: begin
					// Popped value is on the RAM output now.
					res_q   <= ram_rdata;
					count_q <= count_q - CW'(1);
					if (op_q == bdq_pkg::CMD_POP_FRONT) begin
						head_q <= idx_inc(head_q);
					end
					state_q <= S_RESP;
				end
				S_SCAN: begin
					// Compare entry k while the read of entry k + 1 goes out.
					rd_idx_q  <= idx_inc(rd_idx_q);
					cmp_idx_q <= rd_idx_q;
					k_q       <= IW'(k_q + 1'b1);
					if (match) begin
						pos_q <= 4'(k_q);
						if (op_q == bdq_pkg::CMD_REMOVE) begin
							res_q    <= ram_rdata;
							wr_idx_q <= cmp_idx_q;
							left_q   <= IW'(rest);
							if (rest == '0) begin
								count_q <= count_q - CW'(1);
								state_q <= S_RESP;
							end else begin
								state_q <= S_SHIFT;
							end
						end else begin
							state_q <= S_RESP;
						end
					end else if (last_k) begin
						sts_q   <= bdq_pkg::STS_NOT_FOUND;
						state_q <= S_RESP;
					end
				end
				S_SHIFT: begin
					// Move one entry one place toward the front.
					rd_idx_q <= idx_inc(rd_idx_q);
					wr_idx_q <= idx_inc(wr_idx_q);
					left_q   <= IW'(left_q - 1'b1);
					if (left_q == IW'(1)) begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (rsp_load) begin
						rsp_q.status       <= sts_q;
						rsp_q.result_value <= res_q;
						rsp_q.position     <= pos_q;
						rsp_q.occupancy    <= 5'(count_q);
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The entry count never exceeds the capacity.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The head index stays inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n) head_q <= IW'(CAPACITY - 1))
		else $error("head index outside ring");

	// While closing the gap, the write never hits the entry being read.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && left_q > IW'(1)) |-> ram_waddr != ram_raddr)
		else $error("gap closing write collides with read");

	// A new result appears only out of the response state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == S_RESP))
		else $error("result loaded outside response state");

	// A push into a full deque leaves the count unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && is_full && (cmd.payload.command == bdq_pkg::CMD_PUSH_FRONT
		|| cmd.payload.command == bdq_pkg::CMD_PUSH_BACK)) |=> $stable(count_q))
		else $error("push changed a full deque");

endmodule

@@ sim/bounded_deque_with_search_tb.sv @@
// Self-checking testbench for the bounded deque with search and remove-by-value.
`timescale 1ns / 1ps

module bounded_deque_with_search_tb;

	localparam int DEPTH = 16;
	localparam int RANDOM_ITEMS = 500;
	localparam int TAIL_ITEMS = 60;
	localparam int DRAIN_CYCLES = 64;
	localparam int WATCHDOG_NS = 5_000_000;

	// Command codes the block treats as no operation.
	localparam logic [2:0] CMD_NOP_6 = 3'd6;
	localparam logic [2:0] CMD_NOP_7 = 3'd7;

	// Operand extremes.
	localparam logic [31:0] VAL_MIN = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] VAL_ZERO = 32'h0000_0000;
	localparam logic [31:0] VAL_ALL_ONES = 32'hFFFF_FFFF;

	// A queued command with its pacing hints.
	typedef struct {
		bdq_pkg::cmd_item_t item;
		bit                 wait_drain;
		bit                 may_idle;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	bdq_stream_if #(.T(bdq_pkg::cmd_item_t)) cmd_ch ();
	bdq_stream_if #(.T(bdq_pkg::rsp_item_t)) rsp_ch ();

	stim_t              pending_cmds[$];
	bdq_pkg::rsp_item_t expected_rsps[$];
	logic [31:0]        deque_model[$];
	logic [31:0]        value_pool[$];

	int commands_sent;
	int results_seen;
	int mismatch_count = 0;
	int total_items;
	int send_gap;
	int stall_left;
	int calm_left;
	bit quiet_tail;

	bounded_deque_with_search #(
		.CAPACITY(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.rsp   (rsp_ch)
	);

	always #5 clk = ~clk;

	// Apply one command to the mirrored deque and return the result it must produce.
	function automatic bdq_pkg::rsp_item_t deque_apply(bdq_pkg::cmd_item_t c);
		bdq_pkg::rsp_item_t r;
		int        k;
		int        idx;
		bit        found;
		r = '0;
		idx = 0;
		found = 1'b0;
		case (c.command)
			bdq_pkg::CMD_PUSH_FRONT: begin
				if (deque_model.size() >= DEPTH) r.status = bdq_pkg::STS_FULL;
				else deque_model.push_front(c.operand_value);
			end
			bdq_pkg::CMD_PUSH_BACK: begin
				if (deque_model.size() >= DEPTH) r.status = bdq_pkg::STS_FULL;
				else deque_model.push_back(c.operand_value);
			end
			bdq_pkg::CMD_POP_FRONT: begin
				if (deque_model.size() == 0) r.status = bdq_pkg::STS_EMPTY;
				else r.result_value = deque_model.pop_front();
			end
			bdq_pkg::CMD_POP_BACK: begin
				if (deque_model.size() == 0) r.status = bdq_pkg::STS_EMPTY;
				else r.result_value = deque_model.pop_back();
			end
			bdq_pkg::CMD_REMOVE, bdq_pkg::CMD_SEARCH: begin
				if (deque_model.size() == 0) begin
					r.status = bdq_pkg::STS_EMPTY;
				end else begin
					// Only the first match from the front counts.
					for (k = 0; k < deque_model.size(); k++) begin
						if (!found && deque_model[k] == c.operand_value) begin
							found = 1'b1;
							idx = k;
						end
					end
					if (!found) begin
						r.status = bdq_pkg::STS_NOT_FOUND;
					end else begin
						r.position = idx[3:0];
						if (c.command == bdq_pkg::CMD_REMOVE) begin
							r.result_value = deque_model[idx];
							deque_model.delete(idx);
						end
					end
				end
			end
			default: ;
		endcase
		r.occupancy = 5'(deque_model.size());
		return r;
	endfunction

	// Queue one command; pushed values feed the pool used for later matches.
	task automatic add_cmd(input logic [2:0] code, input logic [31:0] value,
			input bit wait_drain, input bit may_idle);
		stim_t s;
		s.item.command = code;
		s.item.operand_value = value;
		s.wait_drain = wait_drain;
		s.may_idle = may_idle;
		pending_cmds.push_back(s);
		if (code == bdq_pkg::CMD_PUSH_FRONT || code == bdq_pkg::CMD_PUSH_BACK) begin
			value_pool.push_back(value);
			if (value_pool.size() > 24) void'(value_pool.pop_front());
		end
	endtask

	// Half the time values that may be stored, else extremes, small duplicates and noise.
	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5 && value_pool.size() > 0) return value_pool[$urandom_range(0, value_pool.size() - 1)];
		if (r == 5) begin
			case ($urandom_range(0, 3))
				0: return VAL_MIN;
				1: return VAL_MAX;
				2: return VAL_ZERO;
				default: return VAL_ALL_ONES;
			endcase
		end
		if (r == 6) return $urandom_range(0, 7);
		return $urandom();
	endfunction

	// Driver: presents pending commands and predicts each accepted one.
	always @(posedge clk or negedge arst_n) begin
		stim_t head_stim;
		if (!arst_n) begin
			cmd_ch.valid <= 1'b0;
			cmd_ch.payload <= '0;
			commands_sent <= 0;
			quiet_tail <= 1'b0;
			send_gap = 0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_rsps.push_back(deque_apply(cmd_ch.payload));
				commands_sent <= commands_sent + 1;
			end
			quiet_tail <= (pending_cmds.size() <= TAIL_ITEMS);
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					cmd_ch.valid <= 1'b0;
					send_gap--;
				end else if (pending_cmds.size() == 0) begin
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds[0].wait_drain && !quiet_tail &&
						(cmd_ch.valid || commands_sent != results_seen)) begin
					// Hold off until every outstanding result has come back.
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds[0].may_idle && !quiet_tail &&
						$urandom_range(0, 5) == 0) begin
					cmd_ch.valid <= 1'b0;
					send_gap = $urandom_range(0, 13);
				end else begin
					head_stim = pending_cmds.pop_front();
					cmd_ch.valid <= 1'b1;
					cmd_ch.payload <= head_stim.item;
				end
			end
		end
	end

	// Monitor: checks each result against the oldest prediction and paces ready.
	always @(posedge clk or negedge arst_n) begin
		bdq_pkg::rsp_item_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			results_seen <= 0;
			stall_left = 0;
			calm_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result item, expected none, got status %0d value %0d",
						$time, rsp_ch.payload.status, rsp_ch.payload.result_value);
					mismatch_count++;
				end else begin
					want = expected_rsps.pop_front();
					if (rsp_ch.payload.status !== want.status) begin
						$display("%0t: status mismatch, expected %0d, got %0d",
							$time, want.status, rsp_ch.payload.status);
						mismatch_count++;
					end
					if (rsp_ch.payload.result_value !== want.result_value) begin
						$display("%0t: result_value mismatch, expected %0d, got %0d",
							$time, want.result_value, rsp_ch.payload.result_value);
						mismatch_count++;
					end
					if (rsp_ch.payload.position !== want.position) begin
						$display("%0t: position mismatch, expected %0d, got %0d",
							$time, want.position, rsp_ch.payload.position);
						mismatch_count++;
					end
					if (rsp_ch.payload.occupancy !== want.occupancy) begin
						$display("%0t: occupancy mismatch, expected %0d, got %0d",
							$time, want.occupancy, rsp_ch.payload.occupancy);
						mismatch_count++;
					end
				end
			end
			// Random stall bursts, broken by calm stretches and a calm tail.
			if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0 || quiet_tail) begin
				rsp_ch.ready <= 1'b1;
				if (calm_left > 0) calm_left--;
			end else if ($urandom_range(0, 49) == 0) begin
				rsp_ch.ready <= 1'b1;
				calm_left = $urandom_range(50, 200);
			end else if ($urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 13);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		int          random_count;
		int          kind;
		int          seg_len;
		int          r;
		int          k;
		bit          seg_idle;
		logic [2:0]  code;
		logic [31:0] first_val;
		logic [31:0] last_val;

		arst_n = 1'b0;

		// Empty deque and unused command codes.
		add_cmd(bdq_pkg::CMD_POP_FRONT, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_POP_BACK, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_REMOVE, VAL_MAX, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_SEARCH, VAL_ZERO, 1'b0, 1'b1);
		add_cmd(CMD_NOP_6, VAL_MIN, 1'b0, 1'b1);
		add_cmd(CMD_NOP_7, VAL_ALL_ONES, 1'b0, 1'b1);
		// Extremes with a duplicate: MAX, MIN, MAX, -1, 0.
		add_cmd(bdq_pkg::CMD_PUSH_BACK, VAL_MAX, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_PUSH_FRONT, VAL_MIN, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_PUSH_BACK, VAL_ALL_ONES, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_PUSH_BACK, VAL_ZERO, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_PUSH_FRONT, VAL_MAX, 1'b0, 1'b1);
		// First match wins, last entry found, a miss.
		add_cmd(bdq_pkg::CMD_SEARCH, VAL_MAX, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_SEARCH, VAL_ZERO, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_SEARCH, 32'h1234_5678, 1'b0, 1'b1);
		// Remove from the middle, at the tail and at the front.
		add_cmd(bdq_pkg::CMD_REMOVE, VAL_ALL_ONES, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_REMOVE, VAL_ZERO, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_REMOVE, VAL_MAX, 1'b0, 1'b1);
		add_cmd(CMD_NOP_6, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_POP_BACK, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_POP_FRONT, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_POP_FRONT, $urandom(), 1'b0, 1'b1);

		// Fill to capacity after a full drain, then push into a full deque.
		random_count = 0;
		first_val = $urandom();
		add_cmd(bdq_pkg::CMD_PUSH_BACK, first_val, 1'b1, 1'b1);
		last_val = first_val;
		for (k = 1; k < DEPTH; k++) begin
			last_val = $urandom();
			add_cmd(bdq_pkg::CMD_PUSH_BACK, last_val, 1'b0, 1'b1);
		end
		add_cmd(bdq_pkg::CMD_PUSH_FRONT, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_PUSH_BACK, $urandom(), 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_SEARCH, last_val, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_REMOVE, last_val, 1'b0, 1'b1);
		add_cmd(bdq_pkg::CMD_REMOVE, first_val, 1'b0, 1'b1);
		random_count += DEPTH + 5;

		// Random segments biased toward filling, draining, matching or noise.
		while (random_count < RANDOM_ITEMS) begin
			kind = $urandom_range(0, 3);
			seg_len = $urandom_range(8, 30);
			seg_idle = ($urandom_range(0, 2) != 0);
			for (k = 0; k < seg_len; k++) begin
				r = $urandom_range(0, 9);
				case (kind)
					0: code = (r < 7) ?
						($urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT) :
						(r == 7) ? bdq_pkg::CMD_SEARCH : (r == 8) ? bdq_pkg::CMD_REMOVE :
						($urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT);
					1: code = (r < 5) ?
						($urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT) :
						(r < 7) ? bdq_pkg::CMD_REMOVE : (r == 7) ? bdq_pkg::CMD_SEARCH :
						($urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT);
					2: code = (r < 3) ?
						($urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_BACK : bdq_pkg::CMD_PUSH_FRONT) :
						(r < 5) ?
						($urandom_range(0, 1) ? bdq_pkg::CMD_POP_BACK : bdq_pkg::CMD_POP_FRONT) :
						(r < 7) ? bdq_pkg::CMD_SEARCH : (r < 9) ? bdq_pkg::CMD_REMOVE :
						3'($urandom_range(0, 7));
					default: code = 3'($urandom_range(0, 7));
				endcase
				add_cmd(code, pick_value(), (k == 0) && ($urandom_range(0, 3) == 0), seg_idle);
			end
			random_count += seg_len;
		end
		total_items = pending_cmds.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (results_seen != total_items) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_rsps.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(WATCHDOG_NS);
		$display("Some tests failed");
		$finish;
	end

endmodule
